FILE: rtl/core/tcw_pkg.sv
package tcw_pkg;

  typedef enum logic [1:0] {
    KIND_DISPLAY = 2'd0,
    KIND_ERASE   = 2'd1,
    KIND_CLEAR   = 2'd2,
    KIND_READ    = 2'd3
  } kind_e;

  typedef struct packed {
    kind_e       kind;
    logic [7:0]  char_code;
    logic [6:0]  cell_col;
    logic [4:0]  cell_row;
  } item_t;

  typedef struct packed {
    logic [6:0]  cursor_col;
    logic [4:0]  cursor_row;
    logic [15:0] cell_value;
    logic [2:0]  printed_count;
  } result_t;

  localparam logic [7:0]  ATTR_RESET = 8'h02;
  localparam logic [7:0]  CH_NEWLINE = 8'd10;
  localparam logic [7:0]  CH_TAB     = 8'd9;
  localparam logic [7:0]  CH_SPACE   = 8'd32;
  localparam logic [15:0] CELL_BLANK = 16'h0000;

endpackage

FILE: rtl/core/tcw_in_if.sv
interface tcw_in_if;
  import tcw_pkg::*;

  logic       valid;
  logic       ready;
  kind_e      kind;
  logic [7:0] char_code;
  logic [6:0] cell_col;
  logic [4:0] cell_row;

  modport source (output valid, output kind, output char_code, output cell_col,
                  output cell_row, input ready);
  modport sink   (input valid, input kind, input char_code, input cell_col,
                  input cell_row, output ready);
endinterface

FILE: rtl/core/tcw_out_if.sv
interface tcw_out_if;
  logic        valid;
  logic        ready;
  logic [6:0]  cursor_col;
  logic [4:0]  cursor_row;
  logic [15:0] cell_value;
  logic [2:0]  printed_count;

  modport source (output valid, output cursor_col, output cursor_row, output cell_value,
                  output printed_count, input ready);
  modport sink   (input valid, input cursor_col, input cursor_row, input cell_value,
                  input printed_count, output ready);
endinterface

FILE: rtl/core/tcw_screen_ram.sv
module tcw_screen_ram #(
  parameter int Depth = 2000,
  parameter int AddrW = 11
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [15:0]      wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [15:0]      rdata_o
);

  logic [15:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

FILE: rtl/core/tcw_engine.sv
module tcw_engine #(
  parameter int COLUMNS      = 80,
  parameter int ROWS         = 25,
  parameter int TAB_SPACES   = 4,
  parameter int PROMPT_WIDTH = 2
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic [7:0]        attr_i,
  input  logic              item_valid_i,
  output logic              item_ready_o,
  input  tcw_pkg::item_t    item_i,
  output logic              res_valid_o,
  input  logic              res_ready_i,
  output tcw_pkg::result_t  res_o
);
  import tcw_pkg::*;

  localparam int Cells      = COLUMNS * ROWS;
  localparam int ScrollLen  = COLUMNS * (ROWS - 1);
  localparam int AW         = $clog2(Cells);
  localparam int CW         = $clog2(COLUMNS);
  localparam int RW         = $clog2(ROWS + 1);
  localparam int TW         = $clog2(TAB_SPACES + 1);

  localparam logic [3:0] ST_INIT   = 4'd0;
  localparam logic [3:0] ST_IDLE   = 4'd1;
  localparam logic [3:0] ST_DECODE = 4'd2;
  localparam logic [3:0] ST_CLEAR  = 4'd3;
  localparam logic [3:0] ST_READ   = 4'd4;
  localparam logic [3:0] ST_CHAR   = 4'd5;
  localparam logic [3:0] ST_WIPE   = 4'd6;
  localparam logic [3:0] ST_PUT    = 4'd7;
  localparam logic [3:0] ST_SCROLL = 4'd8;
  localparam logic [3:0] ST_DRAIN  = 4'd9;
  localparam logic [3:0] ST_NEXT   = 4'd10;
  localparam logic [3:0] ST_RESP   = 4'd11;

  function automatic logic [AW-1:0] cell_addr(input int row, input int col);
    cell_addr = AW'(row * COLUMNS + col);
  endfunction

  logic [3:0]    state_q, state_d;
  logic [CW-1:0] col_q, col_d;
  logic [RW-1:0] line_q, line_d;
  item_t         item_q, item_d;
  logic [7:0]    ch_q, ch_d;
  logic [TW-1:0] rep_q, rep_d;
  logic [TW-1:0] printed_q, printed_d;
  logic [AW-1:0] cnt_q, cnt_d;
  logic          wipe_put_q, wipe_put_d;
  logic          scroll_wipe_q, scroll_wipe_d;
  logic          read_hit_q, read_hit_d;
  logic [15:0]   cell_q, cell_d;
  logic          copy_vld_q;
  logic [AW-1:0] copy_addr_q;

  logic          fsm_we;
  logic [AW-1:0] fsm_waddr;
  logic [15:0]   fsm_wdata;
  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [15:0]   ram_wdata;
  logic          ram_re;
  logic [AW-1:0] ram_raddr;
  logic [15:0]   ram_rdata;
  logic [CW-1:0] erase_col;
  logic          is_tab;

  assign is_tab    = (item_q.char_code == CH_TAB);
  assign erase_col = (int'(col_q) >= PROMPT_WIDTH + 1) ? col_q - CW'(1) : col_q;

  always_comb begin
    state_d       = state_q;
    col_d         = col_q;
    line_d        = line_q;
    item_d        = item_q;
    ch_d          = ch_q;
    rep_d         = rep_q;
    printed_d     = printed_q;
    cnt_d         = cnt_q;
    wipe_put_d    = wipe_put_q;
    scroll_wipe_d = scroll_wipe_q;
    read_hit_d    = read_hit_q;
    cell_d        = cell_q;
    fsm_we        = 1'b0;
    fsm_waddr     = cnt_q;
    fsm_wdata     = CELL_BLANK;
    ram_re        = 1'b0;
    ram_raddr     = cnt_q;
    item_ready_o  = 1'b0;
    res_valid_o   = 1'b0;

    case (state_q)
      ST_INIT, ST_CLEAR: begin
        fsm_we = 1'b1;
        cnt_d  = cnt_q + AW'(1);
        if (cnt_q == AW'(Cells - 1)) begin
          cnt_d   = '0;
          state_d = (state_q == ST_INIT) ? ST_IDLE : ST_RESP;
        end
      end
      ST_IDLE: begin
        item_ready_o = 1'b1;
        if (item_valid_i) begin
          item_d  = item_i;
          state_d = ST_DECODE;
        end
      end
      ST_DECODE: begin
        cell_d    = CELL_BLANK;
        printed_d = '0;
        case (item_q.kind)
          KIND_DISPLAY: begin
            rep_d     = is_tab ? TW'(TAB_SPACES) : TW'(1);
            printed_d = is_tab ? TW'(TAB_SPACES) : TW'(1);
            ch_d      = is_tab ? CH_SPACE : item_q.char_code;
            state_d   = ST_CHAR;
          end
          KIND_ERASE: begin
            if (int'(line_q) < ROWS) begin
              col_d     = erase_col;
              fsm_we    = 1'b1;
              fsm_waddr = cell_addr(int'(line_q), int'(erase_col));
            end
            state_d = ST_RESP;
          end
          KIND_CLEAR: begin
            cnt_d   = '0;
            col_d   = '0;
            line_d  = '0;
            state_d = ST_CLEAR;
          end
          KIND_READ: begin
            read_hit_d = (int'(item_q.cell_col) < COLUMNS) && (int'(item_q.cell_row) < ROWS);
            ram_re     = 1'b1;
            ram_raddr  = cell_addr(int'(item_q.cell_row), int'(item_q.cell_col));
            state_d    = ST_READ;
          end
          default: state_d = ST_RESP;
        endcase
      end
      ST_READ: begin
        cell_d  = read_hit_q ? ram_rdata : CELL_BLANK;
        state_d = ST_RESP;
      end
      ST_CHAR: begin
        cnt_d = '0;
        if (int'(line_q) >= ROWS) begin
          scroll_wipe_d = 1'b1;
          state_d       = ST_SCROLL;
        end else if (ch_q == CH_NEWLINE) begin
          line_d  = line_q + RW'(1);
          col_d   = '0;
          state_d = ST_NEXT;
        end else if (col_q == '0) begin
          wipe_put_d = 1'b1;
          state_d    = ST_WIPE;
        end else begin
          state_d = ST_PUT;
        end
      end
      ST_WIPE: begin
        fsm_we    = 1'b1;
        fsm_waddr = cell_addr(int'(line_q), int'(cnt_q));
        cnt_d     = cnt_q + AW'(1);
        if (cnt_q == AW'(COLUMNS - 1)) begin
          cnt_d   = '0;
          state_d = wipe_put_q ? ST_PUT : ST_CHAR;
        end
      end
      ST_PUT: begin
        fsm_we    = 1'b1;
        fsm_waddr = cell_addr(int'(line_q), int'(col_q));
        fsm_wdata = {attr_i, ch_q};
        cnt_d     = '0;
        state_d   = ST_NEXT;
        if (col_q == CW'(COLUMNS - 1)) begin
          col_d = '0;
          if (int'(line_q) < ROWS - 1) begin
            line_d = line_q + RW'(1);
          end else begin
            scroll_wipe_d = 1'b0;
            state_d       = ST_SCROLL;
          end
        end else begin
          col_d = col_q + CW'(1);
        end
      end
      ST_SCROLL: begin
        ram_re    = 1'b1;
        ram_raddr = cnt_q + AW'(COLUMNS);
        cnt_d     = cnt_q + AW'(1);
        if (cnt_q == AW'(ScrollLen - 1)) begin
          cnt_d   = '0;
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (scroll_wipe_q) begin
          line_d     = RW'(ROWS - 1);
          wipe_put_d = 1'b0;
          state_d    = ST_WIPE;
        end else begin
          state_d = ST_NEXT;
        end
      end
      ST_NEXT: begin
        if (rep_q == TW'(1)) begin
          state_d = ST_RESP;
        end else begin
          rep_d   = rep_q - TW'(1);
          state_d = ST_CHAR;
        end
      end
      ST_RESP: begin
        res_valid_o = 1'b1;
        if (res_ready_i) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // copy path: each cell is written in the cycle after it is read
  assign ram_we    = copy_vld_q | fsm_we;
  assign ram_waddr = copy_vld_q ? copy_addr_q : fsm_waddr;
  assign ram_wdata = copy_vld_q ? ram_rdata : fsm_wdata;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_INIT;
      col_q         <= '0;
      line_q        <= '0;
      cnt_q         <= '0;
      rep_q         <= '0;
      wipe_put_q    <= 1'b0;
      scroll_wipe_q <= 1'b0;
      copy_vld_q    <= 1'b0;
    end else begin
      state_q       <= state_d;
      col_q         <= col_d;
      line_q        <= line_d;
      cnt_q         <= cnt_d;
      rep_q         <= rep_d;
      wipe_put_q    <= wipe_put_d;
      scroll_wipe_q <= scroll_wipe_d;
      copy_vld_q    <= (state_q == ST_SCROLL);
    end
  end

  always_ff @(posedge clk_i) begin
    item_q      <= item_d;
    ch_q        <= ch_d;
    printed_q   <= printed_d;
    read_hit_q  <= read_hit_d;
    cell_q      <= cell_d;
    copy_addr_q <= cnt_q;
  end

  tcw_screen_ram #(
    .Depth (Cells),
    .AddrW (AW)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign res_o.cursor_col    = 7'(col_q);
  assign res_o.cursor_row    = 5'(line_q);
  assign res_o.cell_value    = cell_q;
  assign res_o.printed_count = 3'(printed_q);

endmodule

FILE: rtl/core/text_console_writer.sv
// Text-mode console: a COLUMNS x ROWS screen of 16-bit cells (attribute over
// character), held in one synchronous RAM, and a cursor kept in registers.
// Input channel in_i carries one operation per beat: display a character,
// erase, clear the screen, or read a cell. Output channel out_o returns one
// beat per operation with the cursor, the cell read and the printed count.
// text_attribute_we_i / text_attribute_i load the attribute byte (reset 0x02).
// Work per operation, from the accepting edge to out_o.valid:
//   erase: one cell at most; read: one cell; newline: cursor only;
//   plain character: one cell, plus the row clear at column 0;
//   wrap on the last row: plus the row copy;
//   pending scroll: plus the row copy and last-row clear;
//   tab: TAB_SPACES character passes; clear: a sweep of all cells.
// Sweeps and copies use the single RAM write port, one cell per cycle.
// One operation is in flight at a time; the engine returns to idle, ready
// for the next beat, at the edge that loads a result into the output register.
// After reset the block sweeps zero through all COLUMNS*ROWS cells, with
// in_i.ready low, before taking its first beat.
// A finished result sits in the output register; the next beat is taken
// while it waits, and the engine holds its following result until out_o
// drains.
module text_console_writer #(
  parameter int COLUMNS      = 80,
  parameter int ROWS         = 25,
  parameter int TAB_SPACES   = 4,
  parameter int PROMPT_WIDTH = 2
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       text_attribute_we_i,
  input  logic [7:0] text_attribute_i,
  tcw_in_if.sink     in_i,
  tcw_out_if.source  out_o
);
  import tcw_pkg::*;

  logic [7:0] attr_q;
  item_t      item;
  result_t    res;
  result_t    out_q;
  logic       out_valid_q;
  logic       res_valid;
  logic       res_ready;
  logic       item_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      attr_q <= ATTR_RESET;
    end else if (text_attribute_we_i) begin
      attr_q <= text_attribute_i;
    end
  end

  assign item.kind      = in_i.kind;
  assign item.char_code = in_i.char_code;
  assign item.cell_col  = in_i.cell_col;
  assign item.cell_row  = in_i.cell_row;
  assign in_i.ready     = item_ready;

  tcw_engine #(
    .COLUMNS      (COLUMNS),
    .ROWS         (ROWS),
    .TAB_SPACES   (TAB_SPACES),
    .PROMPT_WIDTH (PROMPT_WIDTH)
  ) u_engine (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .attr_i       (attr_q),
    .item_valid_i (in_i.valid),
    .item_ready_o (item_ready),
    .item_i       (item),
    .res_valid_o  (res_valid),
    .res_ready_i  (res_ready),
    .res_o        (res)
  );

  assign res_ready = !out_valid_q || out_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid && res_ready) begin
      out_q <= res;
    end
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.cursor_col    = out_q.cursor_col;
  assign out_o.cursor_row    = out_q.cursor_row;
  assign out_o.cell_value    = out_q.cell_value;
  assign out_o.printed_count = out_q.printed_count;

  a_ready_excl_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid |-> !item_ready)
    else $error("engine takes a beat while its result is pending");

  a_cursor_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> (int'(out_o.cursor_col) < COLUMNS) && (int'(out_o.cursor_row) <= ROWS))
    else $error("cursor out of range");

  a_display_no_cell: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.printed_count != 3'd0) |-> out_o.cell_value == CELL_BLANK)
    else $error("display result carries a cell value");

  a_load_when_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid && res_ready) |=> out_valid_q)
    else $error("result lost at output register");

endmodule

FILE: sim/text_console_writer_test.sv
`timescale 1ns / 1ps

module text_console_writer_test;
  import tcw_pkg::*;

  localparam int COLS        = 80;
  localparam int NROWS       = 25;
  localparam int TAB_N       = 4;
  localparam int PROMPT_W    = 2;
  localparam int QUIET_LIMIT = 40000;
  localparam int HOLD_CYCLES = 600;
  localparam int PHASE_OPS   = 55;
  localparam int MAX_LINES   = 40;

  typedef enum int {
    SEQ_LINE,
    SEQ_NEWLINES,
    SEQ_TABS,
    SEQ_ERASES,
    SEQ_READS,
    SEQ_CLEAR,
    SEQ_NOISE
  } seq_e;

  typedef struct {
    item_t       op;
    int unsigned reps;
    bit          typed;
    result_t     want;
  } plan_row_t;

  logic       clk_i;
  logic       rst_ni;
  logic       attr_we;
  logic [7:0] attr_val;

  tcw_in_if  in_bus ();
  tcw_out_if out_bus ();

  text_console_writer i_dut (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .text_attribute_we_i (attr_we),
    .text_attribute_i    (attr_val),
    .in_i                (in_bus),
    .out_o               (out_bus)
  );

  // screen and cursor as the block should hold them
  logic [15:0] screen_q [COLS*NROWS];
  int unsigned cur_col;
  int unsigned cur_row;
  logic [7:0]  attr_now;

  result_t     status_due [$];
  plan_row_t   plan [$];
  int unsigned errors;
  int unsigned rx_stall_pct;
  int unsigned hold_req;
  int unsigned hold_seen;
  seq_e        seq_mode;
  int unsigned seq_left;

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  task automatic flag(string msg);
    errors++;
    if (errors <= MAX_LINES) $display("%0t mismatch: %s", $time, msg);
  endtask

  function automatic void blank_row(int unsigned r);
    if (r < NROWS)
      for (int c = 0; c < COLS; c++) screen_q[r*COLS + c] = CELL_BLANK;
  endfunction

  function automatic void roll_up();
    for (int i = 0; i < COLS*(NROWS-1); i++) screen_q[i] = screen_q[i + COLS];
  endfunction

  function automatic void put_glyph(logic [7:0] ch);
    if (cur_row >= NROWS) begin
      roll_up();
      cur_row = NROWS - 1;
      blank_row(cur_row);
    end
    if (ch == CH_NEWLINE) begin
      cur_row++;
      cur_col = 0;
      return;
    end
    if (cur_col == 0) blank_row(cur_row);
    if (cur_col < COLS) screen_q[cur_row*COLS + cur_col] = {attr_now, ch};
    cur_col++;
    if (cur_col >= COLS) begin
      cur_col = 0;
      if (cur_row + 1 < NROWS) cur_row++;
      else roll_up();
    end
  endfunction

  function automatic result_t console_apply(item_t op);
    result_t     r;
    logic [15:0] peek;
    int unsigned shown;
    peek  = CELL_BLANK;
    shown = 0;
    case (op.kind)
      KIND_DISPLAY: begin
        if (op.char_code == CH_TAB) begin
          for (int i = 0; i < TAB_N; i++) put_glyph(CH_SPACE);
          shown = TAB_N;
        end else begin
          put_glyph(op.char_code);
          shown = 1;
        end
      end
      KIND_ERASE: begin
        if (cur_row < NROWS) begin
          if (cur_col >= PROMPT_W + 1) cur_col--;
          if (cur_col < COLS) screen_q[cur_row*COLS + cur_col] = CELL_BLANK;
        end
      end
      KIND_CLEAR: begin
        foreach (screen_q[i]) screen_q[i] = CELL_BLANK;
        cur_col = 0;
        cur_row = 0;
      end
      default: begin
        if (int'(op.cell_col) < COLS && int'(op.cell_row) < NROWS)
          peek = screen_q[int'(op.cell_row)*COLS + int'(op.cell_col)];
      end
    endcase
    r.cursor_col    = cur_col[6:0];
    r.cursor_row    = cur_row[4:0];
    r.cell_value    = peek;
    r.printed_count = shown[2:0];
    return r;
  endfunction

  task automatic match_status(result_t got);
    result_t want;
    if (status_due.size() == 0) begin
      flag($sformatf("result with nothing awaited: %p", got));
      return;
    end
    want = status_due.pop_front();
    if (got.cursor_col !== want.cursor_col)
      flag($sformatf("cursor_col %0d, want %0d", got.cursor_col, want.cursor_col));
    if (got.cursor_row !== want.cursor_row)
      flag($sformatf("cursor_row %0d, want %0d", got.cursor_row, want.cursor_row));
    if (got.cell_value !== want.cell_value)
      flag($sformatf("cell_value %h, want %h", got.cell_value, want.cell_value));
    if (got.printed_count !== want.printed_count)
      flag($sformatf("printed_count %0d, want %0d", got.printed_count, want.printed_count));
  endtask

  task automatic add_row(kind_e k, logic [7:0] ch, logic [6:0] col, logic [4:0] row,
                         int unsigned reps, bit typed, logic [6:0] wc, logic [4:0] wr,
                         logic [15:0] wv, logic [2:0] wn);
    plan_row_t p;
    p.op.kind             = k;
    p.op.char_code        = ch;
    p.op.cell_col         = col;
    p.op.cell_row         = row;
    p.reps                = reps;
    p.typed               = typed;
    p.want.cursor_col     = wc;
    p.want.cursor_row     = wr;
    p.want.cell_value     = wv;
    p.want.printed_count  = wn;
    plan.push_back(p);
  endtask

  task automatic drive_item(item_t op, int unsigned idle_pct, bit typed, result_t want);
    result_t predicted;
    while ($urandom_range(99) < idle_pct) begin
      in_bus.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_bus.valid     <= 1'b1;
    in_bus.kind      <= op.kind;
    in_bus.char_code <= op.char_code;
    in_bus.cell_col  <= op.cell_col;
    in_bus.cell_row  <= op.cell_row;
    do @(posedge clk_i); while (!in_bus.ready);
    predicted = console_apply(op);
    status_due.push_back(typed ? want : predicted);
  endtask

  task automatic drain_results();
    in_bus.valid <= 1'b0;
    do @(posedge clk_i); while (status_due.size() != 0);
  endtask

  task automatic load_attribute(logic [7:0] v);
    drain_results();
    repeat (8) @(posedge clk_i);
    attr_we  <= 1'b1;
    attr_val <= v;
    @(posedge clk_i);
    attr_we  <= 1'b0;
    attr_now = v;
  endtask

  task automatic next_random_op(output item_t op);
    int unsigned r;
    int unsigned rr;
    op.kind      = KIND_DISPLAY;
    op.char_code = 8'($urandom_range(255));
    op.cell_col  = 7'($urandom_range(127));
    op.cell_row  = 5'($urandom_range(31));
    if (seq_left == 0) begin
      r = $urandom_range(99);
      if (r < 35) begin
        seq_mode = SEQ_LINE;
        seq_left = $urandom_range(90, 1);
      end else if (r < 50) begin
        seq_mode = SEQ_NEWLINES;
        seq_left = $urandom_range(30, 1);
      end else if (r < 58) begin
        seq_mode = SEQ_TABS;
        seq_left = $urandom_range(24, 1);
      end else if (r < 68) begin
        seq_mode = SEQ_ERASES;
        seq_left = $urandom_range(5, 1);
      end else if (r < 83) begin
        seq_mode = SEQ_READS;
        seq_left = $urandom_range(4, 1);
      end else if (r < 86) begin
        seq_mode = SEQ_CLEAR;
        seq_left = 1;
      end else begin
        seq_mode = SEQ_NOISE;
        seq_left = $urandom_range(3, 1);
      end
    end
    seq_left--;
    case (seq_mode)
      SEQ_LINE: begin
        if (seq_left == 0) op.char_code = CH_NEWLINE;
      end
      SEQ_NEWLINES: op.char_code = CH_NEWLINE;
      SEQ_TABS:     op.char_code = CH_TAB;
      SEQ_ERASES:   op.kind = KIND_ERASE;
      SEQ_READS: begin
        op.kind = KIND_READ;
        r = $urandom_range(9);
        if (r < 5) begin
          rr = (cur_row >= NROWS) ? NROWS - 1 : cur_row;
          if (rr > 0 && $urandom_range(1) == 1) rr--;
          op.cell_row = 5'(rr);
          op.cell_col = 7'($urandom_range(COLS - 1));
        end else if (r < 8) begin
          op.cell_row = 5'($urandom_range(NROWS - 1));
          op.cell_col = 7'($urandom_range(COLS - 1));
        end
      end
      SEQ_CLEAR:    op.kind = KIND_CLEAR;
      default:      op.kind = kind_e'($urandom_range(3));
    endcase
  endtask

  // receiver: check each beat, stall at random, hold off on request
  initial begin
    int unsigned hold_left;
    result_t     got;
    hold_left = 0;
    out_bus.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_bus.valid && out_bus.ready) begin
        got.cursor_col    = out_bus.cursor_col;
        got.cursor_row    = out_bus.cursor_row;
        got.cell_value    = out_bus.cell_value;
        got.printed_count = out_bus.printed_count;
        match_status(got);
      end
      if (hold_req != hold_seen) begin
        hold_seen = hold_req;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_bus.ready <= 1'b0;
      end else begin
        out_bus.ready <= ($urandom_range(99) >= rx_stall_pct);
      end
    end
  end

  initial begin
    int unsigned quiet;
    quiet = 0;
    forever begin
      @(posedge clk_i);
      if ((in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready)) quiet = 0;
      else quiet++;
      if (quiet >= QUIET_LIMIT) begin
        $display("timeout after %0d quiet cycles", quiet);
        $display("text_console_writer_test: FAIL");
        $finish;
      end
    end
  end

  initial begin
    item_t       op;
    result_t     none;
    int unsigned idle_pct [4];
    int unsigned stall_pct [4];
    logic [7:0]  attr_plan [4];

    idle_pct  = '{0, 74, 0, 34};
    stall_pct = '{0, 0, 74, 34};
    attr_plan = '{8'hFF, 8'h00, 8'($urandom_range(255)), 8'($urandom_range(255))};
    none      = '0;
    errors    = 0;
    hold_req  = 0;
    hold_seen = 0;
    seq_mode  = SEQ_LINE;
    seq_left  = 0;
    rx_stall_pct = 0;
    foreach (screen_q[i]) screen_q[i] = CELL_BLANK;
    cur_col  = 0;
    cur_row  = 0;
    attr_now = ATTR_RESET;

    rst_ni           <= 1'b0;
    attr_we          <= 1'b0;
    attr_val         <= 8'h00;
    in_bus.valid     <= 1'b0;
    in_bus.kind      <= KIND_DISPLAY;
    in_bus.char_code <= 8'h00;
    in_bus.cell_col  <= 7'd0;
    in_bus.cell_row  <= 5'd0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    //      kind          char   col     row    n   typed col    row    value     cnt
    add_row(KIND_READ,    8'h00, 7'd0,   5'd0,  1,  1,    7'd0,  5'd0,  16'h0000, 3'd0);
    add_row(KIND_READ,    8'hFF, 7'd127, 5'd31, 1,  1,    7'd0,  5'd0,  16'h0000, 3'd0);
    add_row(KIND_READ,    8'h00, 7'd79,  5'd24, 1,  1,    7'd0,  5'd0,  16'h0000, 3'd0);
    add_row(KIND_DISPLAY, 8'h41, 7'd127, 5'd31, 1,  1,    7'd1,  5'd0,  16'h0000, 3'd1);
    add_row(KIND_DISPLAY, 8'hFF, 7'd0,   5'd0,  1,  1,    7'd2,  5'd0,  16'h0000, 3'd1);
    add_row(KIND_DISPLAY, 8'h00, 7'd0,   5'd0,  1,  1,    7'd3,  5'd0,  16'h0000, 3'd1);
    add_row(KIND_READ,    8'h00, 7'd1,   5'd0,  1,  1,    7'd3,  5'd0,  16'h02FF, 3'd0);
    add_row(KIND_ERASE,   8'hFF, 7'd127, 5'd31, 1,  1,    7'd2,  5'd0,  16'h0000, 3'd0);
    add_row(KIND_ERASE,   8'h00, 7'd0,   5'd0,  1,  1,    7'd2,  5'd0,  16'h0000, 3'd0);
    add_row(KIND_READ,    8'h00, 7'd1,   5'd0,  1,  1,    7'd2,  5'd0,  16'h02FF, 3'd0);
    add_row(KIND_DISPLAY, CH_TAB, 7'd0,  5'd0,  1,  1,    7'd6,  5'd0,  16'h0000, 3'd4);
    add_row(KIND_DISPLAY, CH_NEWLINE, 7'd0, 5'd0, 1, 1,   7'd0,  5'd1,  16'h0000, 3'd1);
    add_row(KIND_DISPLAY, 8'h42, 7'd0,   5'd0,  1,  0,    7'd0,  5'd0,  16'h0000, 3'd0);
    add_row(KIND_CLEAR,   8'hFF, 7'd127, 5'd31, 1,  1,    7'd0,  5'd0,  16'h0000, 3'd0);
    add_row(KIND_READ,    8'h00, 7'd0,   5'd0,  1,  1,    7'd0,  5'd0,  16'h0000, 3'd0);
    add_row(KIND_DISPLAY, CH_NEWLINE, 7'd0, 5'd0, 24, 0,  7'd0,  5'd0,  16'h0000, 3'd0);
    add_row(KIND_DISPLAY, CH_TAB, 7'd0,  5'd0,  19, 0,    7'd0,  5'd0,  16'h0000, 3'd0);
    add_row(KIND_DISPLAY, 8'h5A, 7'd0,   5'd0,  3,  0,    7'd0,  5'd0,  16'h0000, 3'd0);
    add_row(KIND_DISPLAY, 8'h7E, 7'd0,   5'd0,  1,  0,    7'd0,  5'd0,  16'h0000, 3'd0);
    add_row(KIND_READ,    8'h00, 7'd79,  5'd23, 1,  0,    7'd0,  5'd0,  16'h0000, 3'd0);
    add_row(KIND_ERASE,   8'h00, 7'd0,   5'd0,  1,  0,    7'd0,  5'd0,  16'h0000, 3'd0);
    add_row(KIND_DISPLAY, CH_NEWLINE, 7'd0, 5'd0, 1, 0,   7'd0,  5'd0,  16'h0000, 3'd0);
    add_row(KIND_ERASE,   8'h00, 7'd0,   5'd0,  1,  0,    7'd0,  5'd0,  16'h0000, 3'd0);
    add_row(KIND_READ,    8'h00, 7'd0,   5'd23, 1,  0,    7'd0,  5'd0,  16'h0000, 3'd0);
    add_row(KIND_DISPLAY, 8'h43, 7'd0,   5'd0,  1,  0,    7'd0,  5'd0,  16'h0000, 3'd0);
    add_row(KIND_READ,    8'h00, 7'd0,   5'd24, 1,  0,    7'd0,  5'd0,  16'h0000, 3'd0);

    foreach (plan[i])
      repeat (plan[i].reps) drive_item(plan[i].op, 0, plan[i].typed, plan[i].want);

    for (int ph = 0; ph < 4; ph++) begin
      load_attribute(attr_plan[ph]);
      rx_stall_pct = stall_pct[ph];
      if (ph == 0) hold_req++;
      for (int n = 0; n < PHASE_OPS; n++) begin
        if (ph == 1 && n == PHASE_OPS/2) drain_results();
        next_random_op(op);
        drive_item(op, idle_pct[ph], 1'b0, none);
      end
    end

    in_bus.valid <= 1'b0;
    while (status_due.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (errors == 0 && status_due.size() == 0) begin
      $display("text_console_writer_test: PASS");
    end else begin
      $display("text_console_writer_test: FAIL");
    end
    $finish;
  end

endmodule

FILE: text_console_writer.f
rtl/core/tcw_pkg.sv
rtl/core/tcw_in_if.sv
rtl/core/tcw_out_if.sv
rtl/core/tcw_screen_ram.sv
rtl/core/tcw_engine.sv
rtl/core/text_console_writer.sv
sim/text_console_writer_test.sv
